[sv/mkd_pkg.sv]
// ============================================================================
// mkd_pkg
// Shared types and constants for the matrix keypad debouncer.
// ============================================================================
package mkd_pkg;

    // Key slots carried by one scan beat (fixed by the sample field width)
    localparam int KEY_SLOTS   = 16;
    localparam int KEY_IDX_W   = 4;
    localparam int CNT_W       = 8;

    localparam int DEF_ROWS    = 4;
    localparam int DEF_COLS    = 4;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd5;

    // Register map: register index taken from paddr[2]
    localparam logic REG_DEBOUNCE = 1'b0;

    // Per-lane control, common to all lanes
    typedef struct packed {
        logic             accept;   // scan beat taken this cycle
        logic [CNT_W-1:0] thr;      // effective threshold, never zero
    } lane_ctrl_t;

    // One result beat
    typedef struct packed {
        logic                 query_pressed;
        logic [KEY_SLOTS-1:0] pressed_keys;
    } result_t;

endpackage

[sv/mkd_lane.sv]
// ============================================================================
// mkd_lane
// Debounce core for one key: debounced state plus disagreement counter.
// ============================================================================
module mkd_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mkd_pkg::lane_ctrl_t  ctrl,
    input  logic                 sample,
    output logic                 pressed_next,   // state after this beat
    output logic                 pressed
);

    logic                       pressed_reg;
    logic [mkd_pkg::CNT_W-1:0]  count_reg;
    logic [mkd_pkg::CNT_W-1:0]  count_next;
    logic [mkd_pkg::CNT_W:0]    count_inc;

    assign count_inc = {1'b0, count_reg} + {{mkd_pkg::CNT_W{1'b0}}, 1'b1};

    always_comb begin
        pressed_next = pressed_reg;
        count_next   = count_reg;
        if (sample == pressed_reg) begin
            count_next = '0;
        end else if (count_inc >= {1'b0, ctrl.thr}) begin
            pressed_next = ~pressed_reg;
            count_next   = '0;
        end else begin
            count_next = count_inc[mkd_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressed_reg <= 1'b0;
            count_reg   <= '0;
        end else if (ctrl.accept) begin
            pressed_reg <= pressed_next;
            count_reg   <= count_next;
        end
    end

    assign pressed = pressed_reg;

    // counter clears on reaching the threshold, which is at most 255
    a_count_below_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != {mkd_pkg::CNT_W{1'b1}})
        else $error("sample counter reached all ones");

    a_hold_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctrl.accept |=> $stable(pressed_reg) && $stable(count_reg))
        else $error("key state moved without a scan beat");

endmodule

[sv/mkd_merge.sv]
// ============================================================================
// mkd_merge
// Collects lane states into the result beat; output register plus skid.
// ============================================================================
module mkd_merge (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  accept,
    input  logic [mkd_pkg::KEY_SLOTS-1:0]         pressed_next,
    input  logic [mkd_pkg::KEY_IDX_W-1:0]         query_key,
    output logic                                  in_ready,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output mkd_pkg::result_t                      out_data
);

    mkd_pkg::result_t new_res;
    mkd_pkg::result_t out_data_reg;
    mkd_pkg::result_t skid_data_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             pop;

    // slots outside the matrix are tied low, so a query there reads 0
    assign new_res.pressed_keys  = pressed_next;
    assign new_res.query_pressed = pressed_next[query_key];

    assign pop      = out_valid_reg && out_ready;
    assign in_ready = ~skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (accept) begin
            if (!out_valid_reg || pop) begin
                out_data_reg <= new_res;
            end else begin
                skid_data_reg <= new_res;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output is empty");

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg)
        else $error("accepted beat not presented");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> !accept)
        else $error("beat accepted with skid full");

endmodule

[sv/matrix_keypad_debouncer.sv]
// ============================================================================
// matrix_keypad_debouncer
// Counter-based debouncer for a ROWS x COLS key matrix, all keys in parallel.
// ============================================================================
// Usage:
//   s_ channel: one beat per scan tick, raw contact level of every key
//     (bit row*COLS+col, 1 = closed) and the index of a key to report.
//   m_ channel: one beat per scan beat, the debounced pressed bitmap after
//     the update and the state of the queried key.
//   APB port: register 0 (byte address 0) is debounce_samples, the number
//     of consecutive disagreeing samples before a key toggles; 0 acts as 1.
//     Write only while the block is idle.
// Result path: the result is registered in the output stage before it appears on m_.
// Throughput: one beat per cycle while s_tready is high; every key has its own lane, so the whole
//   matrix updates in the accepting cycle.
// Stall: a two-entry output stage (register plus skid) keeps s_tready high
//   while one result waits; s_tready drops only when both entries are full.
// Reset (aresetn low, synchronous): all keys released, counters zero,
//   threshold back to 5, output stage empty.
// Keys beyond min(ROWS*COLS, 16) have no lane and always read released.
// ============================================================================
module matrix_keypad_debouncer #(
    parameter int ROWS = mkd_pkg::DEF_ROWS,
    parameter int COLS = mkd_pkg::DEF_COLS
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // scan beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [15:0] key_samples, [19:16] query_key, rest 0
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // [15:0] pressed_keys, [16] query_pressed, rest 0
);

    localparam int MATRIX_KEYS = ROWS * COLS;
    localparam int ACTIVE_KEYS = (MATRIX_KEYS > mkd_pkg::KEY_SLOTS) ?
                                 mkd_pkg::KEY_SLOTS : MATRIX_KEYS;

    logic [mkd_pkg::CNT_W-1:0]      debounce_reg;
    logic                           cfg_write;
    logic                           accept;
    mkd_pkg::lane_ctrl_t            lane_ctrl;
    logic [mkd_pkg::KEY_SLOTS-1:0]  key_samples;
    logic [mkd_pkg::KEY_IDX_W-1:0]  query_key;
    logic [mkd_pkg::KEY_SLOTS-1:0]  pressed_next;
    logic [mkd_pkg::KEY_SLOTS-1:0]  pressed_now;
    mkd_pkg::result_t               result;

    // ---------------- configuration register ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == mkd_pkg::REG_DEBOUNCE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= mkd_pkg::DEBOUNCE_RESET;
        end else if (cfg_write) begin
            debounce_reg <= pwdata[mkd_pkg::CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == mkd_pkg::REG_DEBOUNCE) ?
                    {{(32-mkd_pkg::CNT_W){1'b0}}, debounce_reg} : 32'd0;

    // ---------------- scan beat fan-out ----------------
    assign key_samples = s_tdata[15:0];
    assign query_key   = s_tdata[19:16];
    assign accept      = s_tvalid && s_tready;

    assign lane_ctrl.accept = accept;
    // zero threshold behaves as one
    assign lane_ctrl.thr    = (debounce_reg == '0) ?
                              {{(mkd_pkg::CNT_W-1){1'b0}}, 1'b1} : debounce_reg;

    // one lane per key in the matrix; spare slots stay released
    for (genvar k = 0; k < mkd_pkg::KEY_SLOTS; k++) begin : g_lane
        if (k < ACTIVE_KEYS) begin : g_key
            mkd_lane u_lane (
                .aclk         (aclk),
                .aresetn      (aresetn),
                .ctrl         (lane_ctrl),
                .sample       (key_samples[k]),
                .pressed_next (pressed_next[k]),
                .pressed      (pressed_now[k])
            );
        end else begin : g_spare
            assign pressed_next[k] = 1'b0;
            assign pressed_now[k]  = 1'b0;
        end
    end

    // ---------------- merge and output stage ----------------
    mkd_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .pressed_next (pressed_next),
        .query_key    (query_key),
        .in_ready     (s_tready),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_data     (result)
    );

    assign m_tdata = {7'd0, result.query_pressed, result.pressed_keys};

    // latched states only move on an accepted scan beat
    a_state_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(pressed_now))
        else $error("debounced bitmap changed without a scan beat");

    // the presented bitmap matches the lanes in the cycle after an accept that finds the output free
    a_result_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (!m_tvalid || m_tready)) |=> (result.pressed_keys == pressed_now))
        else $error("result bitmap differs from lane state");

    // threshold never reaches the lanes as zero
    a_thr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lane_ctrl.thr != '0)
        else $error("zero debounce threshold");

endmodule

[bench/tb.sv]
// ============================================================================
// tb
// Self-checking bench for the matrix keypad debouncer: a directed table,
// then random debounce phases at several thresholds, all scoreboarded.
// ============================================================================
// Scan beats go in on s_, result beats are checked on m_ against an
// in-bench model of the per-key counters. The threshold register is written
// over APB between phases, only while the block is drained.
// ============================================================================
module tb;

    localparam int ROWS = mkd_pkg::DEF_ROWS;
    localparam int COLS = mkd_pkg::DEF_COLS;
    // keys that really exist; higher sample bits are ignored by the block
    localparam int ACTIVE_KEYS = (ROWS * COLS > mkd_pkg::KEY_SLOTS) ?
                                 mkd_pkg::KEY_SLOTS : ROWS * COLS;

    // register addresses: index sits in paddr[2]
    localparam logic [2:0] ADDR_DEBOUNCE = {mkd_pkg::REG_DEBOUNCE, 2'b00};
    localparam logic [2:0] ADDR_SPARE    = {~mkd_pkg::REG_DEBOUNCE, 2'b00};

    localparam int SETTLE_CYCLES  = 4;     // margin after the last result drains
    localparam int LONG_HOLD      = 40;    // receiver hold-off to fill the skid
    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no beat on s_ or m_
    localparam int NUM_DIRECTED   = 28;
    localparam int NUM_PHASES     = 9;

    typedef enum logic {ROW_SCAN, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [2:0]         addr;
        logic [31:0]        wdata;
        logic [15:0]        samples;
        logic [3:0]         query;
        bit                 typed;     // want holds a hand-written result
        mkd_pkg::result_t   want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] key_samples, [19:16] query_key, rest 0
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [15:0] pressed_keys, [16] query_pressed, rest 0

    // model of the debouncer
    logic [mkd_pkg::CNT_W-1:0] debounce_thr;
    logic                      key_state [mkd_pkg::KEY_SLOTS];
    logic [mkd_pkg::CNT_W-1:0] key_count [mkd_pkg::KEY_SLOTS];

    mkd_pkg::result_t pending_results [$];
    int      fail_count = 0;
    bit      idle_on    = 1'b1;
    bit      long_hold  = 1'b0;
    int      stall_left = 0;
    int      quiet_cycles = 0;

    // Directed table. Typed rows: after reset, all-on/all-off extremes,
    // threshold zero acting as one, the spare address being ignored, and a
    // threshold lowered under a running count.
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        // reset state, threshold 5
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h0000, 4'd0,  1'b1, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'hFFFF, 4'd15, 1'b1, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'hFFFF, 4'd15, 1'b1, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'hFFFF, 4'd15, 1'b1, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'hFFFF, 4'd15, 1'b1, {1'b0, 16'h0000}},
        // fifth disagreeing sample toggles every key
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'hFFFF, 4'd15, 1'b1, {1'b1, 16'hFFFF}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h0000, 4'd3,  1'b1, {1'b1, 16'hFFFF}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'hFFFF, 4'd3,  1'b0, {1'b0, 16'h0000}},
        // zero threshold behaves as one
        '{ROW_WRITE, ADDR_DEBOUNCE, 32'd0,   16'h0000, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h0000, 4'd0,  1'b1, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'hA5A5, 4'd0,  1'b1, {1'b1, 16'hA5A5}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h5A5A, 4'd1,  1'b1, {1'b1, 16'h5A5A}},
        // spare address: threshold must stay at one
        '{ROW_WRITE, ADDR_SPARE,    32'h77,  16'h0000, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h0000, 4'd7,  1'b1, {1'b0, 16'h0000}},
        // run the low keys up to a count of 7 under threshold 10
        '{ROW_WRITE, ADDR_DEBOUNCE, 32'd10,  16'h0000, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h00FF, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h00FF, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h00FF, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h00FF, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h00FF, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h00FF, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h00FF, 4'd0,  1'b0, {1'b0, 16'h0000}},
        // lowered under the running count: next disagreeing sample toggles
        '{ROW_WRITE, ADDR_DEBOUNCE, 32'd3,   16'h0000, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h00FF, 4'd0,  1'b1, {1'b1, 16'h00FF}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'hFF00, 4'd8,  1'b1, {1'b0, 16'h00FF}},
        // top threshold
        '{ROW_WRITE, ADDR_DEBOUNCE, 32'd255, 16'h0000, 4'd0,  1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'hFFFF, 4'd15, 1'b0, {1'b0, 16'h0000}},
        '{ROW_SCAN,  ADDR_DEBOUNCE, 32'd0,   16'h0000, 4'd4,  1'b0, {1'b0, 16'h0000}}
    };

    // thresholds of the random phases; the last phase runs with no idling
    logic [mkd_pkg::CNT_W-1:0] phase_thr [NUM_PHASES] = '{
        8'd1, 8'd2, 8'd0, 8'd3, 8'd255, 8'd4, 8'd7, 8'd5, 8'd1
    };

    matrix_keypad_debouncer #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One scan tick through the key model: agree clears, disagree counts,
    // reaching the threshold toggles and clears.
    function automatic mkd_pkg::result_t debounce_step(input logic [15:0] samples,
                                                       input logic [3:0]  query);
        logic [mkd_pkg::CNT_W:0] next_cnt;
        logic [mkd_pkg::CNT_W:0] eff_thr;
        mkd_pkg::result_t        res;
        eff_thr = (debounce_thr == '0) ? 9'd1 : {1'b0, debounce_thr};
        res = '0;
        for (int k = 0; k < ACTIVE_KEYS; k++) begin
            if (samples[k] == key_state[k]) begin
                key_count[k] = '0;
            end else begin
                next_cnt = {1'b0, key_count[k]} + 1'b1;
                if (next_cnt >= eff_thr) begin
                    key_state[k] = ~key_state[k];
                    next_cnt = '0;
                end
                key_count[k] = next_cnt[mkd_pkg::CNT_W-1:0];
            end
            res.pressed_keys[k] = key_state[k];
        end
        res.query_pressed = (int'(query) < ACTIVE_KEYS) ? key_state[query] : 1'b0;
        return res;
    endfunction

    // Offer one scan beat, optionally after a short gap, step the key model once
    // it is taken, and log the model's result or the typed one.
    task automatic send_scan(input logic [15:0] samples, input logic [3:0] query,
                             input bit typed, input mkd_pkg::result_t typed_res);
        int               gap;
        mkd_pkg::result_t res;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, query, samples};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        res = debounce_step(samples, query);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // stop offering, let every result drain, then wait out the settle margin
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // setup cycle, then access cycle; write lands when pready is seen high
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == mkd_pkg::REG_DEBOUNCE)
            debounce_thr = value[mkd_pkg::CNT_W-1:0];
    endtask

    // main stimulus
    initial begin
        logic [15:0] target;
        logic [15:0] samples;
        int          eff;
        int          burst_len;
        int          phase_items;
        int          sent;
        int          pick;
        bit          clean;

        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;

        debounce_thr = mkd_pkg::DEBOUNCE_RESET;
        for (int k = 0; k < mkd_pkg::KEY_SLOTS; k++) begin
            key_state[k] = 1'b0;
            key_count[k] = '0;
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE) begin
                wait_idle();
                reg_write(directed_rows[i].addr, directed_rows[i].wdata);
            end else begin
                send_scan(directed_rows[i].samples, directed_rows[i].query,
                          directed_rows[i].typed, directed_rows[i].want);
            end
        end

        // random phases: mostly held patterns long enough to toggle keys,
        // with bounce and noise mixed in where the threshold is short
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            reg_write(ADDR_DEBOUNCE, {24'd0, phase_thr[p]});
            if (p == 1)
                long_hold = 1'b1;     // back up the output stage once
            if (p == NUM_PHASES - 1)
                idle_on = 1'b0;       // closing stretch at full rate
            eff = (phase_thr[p] == '0) ? 1 : int'(phase_thr[p]);
            phase_items = (eff > 16) ? 400 : 130;
            sent = 0;
            while (sent < phase_items) begin
                target    = 16'($urandom_range(0, 16'hFFFF));
                burst_len = eff + $urandom_range(0, (eff > 16) ? 40 : 2 * eff + 4);
                clean     = (eff > 16) || ($urandom_range(0, 3) == 0);
                for (int n = 0; n < burst_len; n++) begin
                    pick = $urandom_range(0, 15);
                    if (!clean && pick == 0)
                        samples = 16'($urandom_range(0, 16'hFFFF));
                    else if (!clean && pick < 3)
                        samples = target ^ (16'h0001 << $urandom_range(0, 15));
                    else
                        samples = target;
                    send_scan(samples, 4'($urandom_range(0, 15)), 1'b0, '0);
                    sent++;
                end
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver: random short stalls, one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!aresetn) begin
                m_tready <= 1'b0;
            end else if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
                m_tready <= 1'b1;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                stall_left = $urandom_range(1, 4) - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker: oldest expectation against each result beat
    always @(posedge aclk) begin
        mkd_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected, m_tdata=%h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[15:0] !== want.pressed_keys) begin
                    $error("pressed_keys: expected %h, got %h",
                           want.pressed_keys, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[16] !== want.query_pressed) begin
                    $error("query_pressed: expected %b, got %b",
                           want.query_pressed, m_tdata[16]);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: too long without a beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

[sim.f]
sv/mkd_pkg.sv
sv/mkd_lane.sv
sv/mkd_merge.sv
sv/matrix_keypad_debouncer.sv
bench/tb.sv
